// File: src/osa_pkg.sv
// Shared constants and token control type for the edit distance cell chain.
package osa_pkg;

  localparam int SYM_W           = 21;
  localparam int DIST_W          = 7;
  localparam int MAX_LEN_DEF     = 64;
  localparam int SYMBOL_BITS_DEF = 21;

  // Control bits that travel with each wavefront token
  typedef struct packed {
    logic valid;    // token present in this slot
    logic upd;      // token carries a symbol that advances the column
    logic fin;      // token closes the comparison and collects the distance
    logic at_edge;  // token comes straight from the column head (no left symbol)
    logic jgt1;     // column index of this symbol is above one
  } tok_ctl_t;

endpackage

// File: src/osa_cell.sv
// One first-string position: stores its symbol and its two column entries.
module osa_cell import osa_pkg::*; #(
  parameter int IDX   = 1,
  parameter int CMP_W = SYMBOL_BITS_DEF,
  parameter int VW    = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             flush,
  input  logic             init,
  input  logic             wr_en,
  input  logic [VW-1:0]    wr_idx,
  input  logic [CMP_W-1:0] wr_sym,
  input  logic [VW-1:0]    len,
  input  tok_ctl_t         in_ctl,
  input  logic [CMP_W-1:0] in_c,
  input  logic [CMP_W-1:0] in_pc,
  input  logic [CMP_W-1:0] in_a,
  input  logic [VW-1:0]    in_n,
  input  logic [VW-1:0]    in_d,
  input  logic [VW-1:0]    in_q,
  input  logic [VW-1:0]    in_r,
  input  logic [VW-1:0]    in_dist,
  output tok_ctl_t         out_ctl,
  output logic [CMP_W-1:0] out_c,
  output logic [CMP_W-1:0] out_pc,
  output logic [CMP_W-1:0] out_a,
  output logic [VW-1:0]    out_n,
  output logic [VW-1:0]    out_d,
  output logic [VW-1:0]    out_q,
  output logic [VW-1:0]    out_r,
  output logic [VW-1:0]    out_dist
);

  localparam logic [VW-1:0] MY_IDX = VW'(IDX);
  localparam logic [VW-1:0] WR_POS = VW'(IDX - 1);

  logic [CMP_W-1:0] sym_r;
  logic [VW-1:0]    cur_r;
  logic [VW-1:0]    prv_r;

  tok_ctl_t         ctl_r;
  logic [CMP_W-1:0] c_r, pc_r;
  logic [VW-1:0]    n_r, d_r, q_r, r_r, dist_r;

  logic             cost;
  logic             swap;
  logic             step;
  logic [VW:0]      up_v, left_v, diag_v, trn_v, best1, best;
  logic [VW-1:0]    v;

  // Evaluate the recurrence for this position
  always_comb begin
    cost   = (sym_r != in_c);
    up_v   = {1'b0, cur_r} + (VW+1)'(1);
    left_v = {1'b0, in_n} + (VW+1)'(1);
    diag_v = {1'b0, in_d} + {{VW{1'b0}}, cost};
    trn_v  = {1'b0, in_r} + {{VW{1'b0}}, cost};
    best1  = (up_v < left_v) ? up_v : left_v;
    best1  = (diag_v < best1) ? diag_v : best1;
    swap   = !in_ctl.at_edge && in_ctl.jgt1 && (sym_r == in_pc) && (in_a == in_c);
    best   = (swap && (trn_v < best1)) ? trn_v : best1;
    v      = best[VW-1:0];
    step   = in_ctl.valid && in_ctl.upd;
  end

  // Hold the stored first-string symbol
  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == WR_POS)) begin
      sym_r <= wr_sym;
    end
  end

  // Initialise or advance the column entries
  always_ff @(posedge clk) begin
    if (init) begin
      cur_r <= MY_IDX;
      prv_r <= MY_IDX;
    end else if (step) begin
      prv_r <= cur_r;
      cur_r <= v;
    end
  end

  // Token control towards the next cell
  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= '{valid: in_ctl.valid, upd: in_ctl.upd, fin: in_ctl.fin,
                 at_edge: 1'b0, jgt1: in_ctl.jgt1};
    end
  end

  // Token payload towards the next cell; pick up the distance at the string end
  always_ff @(posedge clk) begin
    c_r    <= in_c;
    pc_r   <= in_pc;
    n_r    <= v;
    d_r    <= cur_r;
    q_r    <= prv_r;
    r_r    <= in_q;
    dist_r <= (len == MY_IDX) ? (step ? v : cur_r) : in_dist;
  end

  assign out_ctl  = ctl_r;
  assign out_c    = c_r;
  assign out_pc   = pc_r;
  assign out_a    = sym_r;
  assign out_n    = n_r;
  assign out_d    = d_r;
  assign out_q    = q_r;
  assign out_r    = r_r;
  assign out_dist = dist_r;

endmodule

// File: src/osa_edit_distance.sv
// The result token is registered at the column head and then in each of the MAX_LEN cells.
// Throughput: one item per cycle while either string streams in; busy stays high from
// the second string's last item until its result leaves the chain of MAX_LEN cells.
// Reset clears the control state; stored symbols stay undefined until written.
// The receiver cannot stall: out_valid is high for exactly one cycle per result.
module osa_edit_distance import osa_pkg::*; #(
  parameter int MAX_LEN     = MAX_LEN_DEF,
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_string_select,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic              in_is_last,
  input  logic              in_is_empty,
  output logic              out_valid,
  output logic [DIST_W-1:0] out_distance,
  output logic              out_overflow
);

  localparam int CMP_W = (SYMBOL_BITS < SYM_W) ? SYMBOL_BITS : SYM_W;
  localparam int VW    = $clog2(MAX_LEN + 1);
  localparam logic [VW-1:0] LEN_MAX = VW'(MAX_LEN);

  // Token links between cells; slot 0 is the column head
  tok_ctl_t         ctl  [0:MAX_LEN];
  logic [CMP_W-1:0] tc   [0:MAX_LEN];
  logic [CMP_W-1:0] tpc  [0:MAX_LEN];
  logic [CMP_W-1:0] ta   [0:MAX_LEN];
  logic [VW-1:0]    tn   [0:MAX_LEN];
  logic [VW-1:0]    td   [0:MAX_LEN];
  logic [VW-1:0]    tq   [0:MAX_LEN];
  logic [VW-1:0]    tr   [0:MAX_LEN];
  logic [VW-1:0]    tdist[0:MAX_LEN];

  // Controller state
  logic [VW-1:0]    len_r, len_nxt;
  logic [VW-1:0]    cnt_r, cnt_nxt;
  logic [CMP_W-1:0] pc_r, pc_nxt;
  logic             loading_r, loading_nxt;
  logic             ovf_r, ovf_nxt;
  logic             pending_r, pending_nxt;

  // Column head token
  tok_ctl_t         src_ctl_r, src_ctl_nxt;
  logic [CMP_W-1:0] src_c_r, src_pc_r;
  logic [VW-1:0]    src_n_r, src_d_r, src_q_r, src_dist_r, src_dist_nxt;

  logic             acc;
  logic             ign;
  logic             emit;
  logic             flush;
  logic             init;
  logic             wr_en;
  logic [VW-1:0]    wr_idx;
  logic [CMP_W-1:0] sym_in;
  logic [VW-1:0]    eff_len;
  logic [VW-1:0]    cnt_b;
  logic [CMP_W-1:0] pc_b;
  logic             step_ok;

  assign sym_in = in_symbol[CMP_W-1:0];
  assign acc    = start && !busy;
  assign ign    = in_is_empty && !in_is_last;
  assign emit   = ctl[MAX_LEN].valid && ctl[MAX_LEN].fin;

  // Decide loads, column starts and token launches
  always_comb begin
    len_nxt      = len_r;
    cnt_nxt      = cnt_r;
    pc_nxt       = pc_r;
    loading_nxt  = loading_r;
    ovf_nxt      = ovf_r;
    pending_nxt  = pending_r;
    flush        = 1'b0;
    init         = 1'b0;
    wr_en        = 1'b0;
    eff_len      = loading_r ? '0 : len_r;
    wr_idx       = eff_len;
    cnt_b        = loading_r ? cnt_r : '0;
    pc_b         = loading_r ? pc_r : '0;
    step_ok      = !in_is_empty && (cnt_b < LEN_MAX);
    src_ctl_nxt  = '{valid: 1'b0, upd: 1'b0, fin: 1'b0, at_edge: 1'b1, jgt1: 1'b0};
    src_dist_nxt = cnt_b + VW'(1);

    // Drop the finished comparison once its result leaves the chain
    if (emit) begin
      len_nxt     = '0;
      cnt_nxt     = '0;
      pc_nxt      = '0;
      loading_nxt = 1'b0;
      ovf_nxt     = 1'b0;
      pending_nxt = 1'b0;
    end

    if (acc && !ign) begin
      if (!in_string_select) begin
        // First string: abandon any comparison and store the symbol
        flush       = 1'b1;
        len_nxt     = eff_len;
        ovf_nxt     = loading_r ? 1'b0 : ovf_r;
        loading_nxt = 1'b0;
        cnt_nxt     = '0;
        pc_nxt      = '0;
        if (!in_is_empty) begin
          if (eff_len < LEN_MAX) begin
            wr_en   = 1'b1;
            len_nxt = eff_len + VW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        if (in_is_last) begin
          init        = 1'b1;
          loading_nxt = 1'b1;
        end
      end else begin
        // Second string: launch a wavefront token into the chain
        init        = !loading_r;
        loading_nxt = 1'b1;
        cnt_nxt     = cnt_b;
        pc_nxt      = pc_b;
        if (!in_is_empty && !step_ok) begin
          ovf_nxt = 1'b1;
        end
        if (step_ok) begin
          cnt_nxt           = cnt_b + VW'(1);
          pc_nxt            = sym_in;
          src_ctl_nxt.valid = 1'b1;
          src_ctl_nxt.upd   = 1'b1;
          src_ctl_nxt.jgt1  = (cnt_b != '0);
        end
        if (in_is_last) begin
          src_ctl_nxt.valid = 1'b1;
          src_ctl_nxt.fin   = 1'b1;
          pending_nxt       = 1'b1;
          if (!step_ok) begin
            src_dist_nxt = cnt_b;
          end
        end
      end
    end
  end

  // Hold controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      cnt_r     <= '0;
      pc_r      <= '0;
      loading_r <= 1'b0;
      ovf_r     <= 1'b0;
      pending_r <= 1'b0;
      src_ctl_r <= '0;
    end else begin
      len_r     <= len_nxt;
      cnt_r     <= cnt_nxt;
      pc_r      <= pc_nxt;
      loading_r <= loading_nxt;
      ovf_r     <= ovf_nxt;
      pending_r <= pending_nxt;
      src_ctl_r <= src_ctl_nxt;
    end
  end

  // Column head payload: row index entries for the new symbol
  always_ff @(posedge clk) begin
    src_c_r    <= sym_in;
    src_pc_r   <= pc_b;
    src_n_r    <= cnt_b + VW'(1);
    src_d_r    <= cnt_b;
    src_q_r    <= cnt_b - VW'(1);
    src_dist_r <= src_dist_nxt;
  end

  assign ctl[0]   = src_ctl_r;
  assign tc[0]    = src_c_r;
  assign tpc[0]   = src_pc_r;
  assign ta[0]    = '0;
  assign tn[0]    = src_n_r;
  assign td[0]    = src_d_r;
  assign tq[0]    = src_q_r;
  assign tr[0]    = '0;
  assign tdist[0] = src_dist_r;

  // Row of cells, one per first-string position
  for (genvar k = 1; k <= MAX_LEN; k++) begin : g_cell
    osa_cell #(
      .IDX   (k),
      .CMP_W (CMP_W),
      .VW    (VW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .flush    (flush),
      .init     (init),
      .wr_en    (wr_en),
      .wr_idx   (wr_idx),
      .wr_sym   (sym_in),
      .len      (len_r),
      .in_ctl   (ctl[k-1]),
      .in_c     (tc[k-1]),
      .in_pc    (tpc[k-1]),
      .in_a     (ta[k-1]),
      .in_n     (tn[k-1]),
      .in_d     (td[k-1]),
      .in_q     (tq[k-1]),
      .in_r     (tr[k-1]),
      .in_dist  (tdist[k-1]),
      .out_ctl  (ctl[k]),
      .out_c    (tc[k]),
      .out_pc   (tpc[k]),
      .out_a    (ta[k]),
      .out_n    (tn[k]),
      .out_d    (td[k]),
      .out_q    (tq[k]),
      .out_r    (tr[k]),
      .out_dist (tdist[k])
    );
  end

  // Result transfer straight from the chain tail
  assign busy         = pending_r;
  assign out_valid    = emit;
  assign out_distance = DIST_W'(tdist[MAX_LEN]);
  assign out_overflow = ovf_r;

endmodule

// File: tb/osa_edit_distance_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the optimal string alignment edit distance block.
module osa_edit_distance_tb;
  import osa_pkg::*;

  localparam int   MAX_LEN     = MAX_LEN_DEF;
  localparam logic SEL_FIRST   = 1'b0;
  localparam logic SEL_SECOND  = 1'b1;
  localparam int   IDLE_LIMIT  = 1000;
  localparam int   TOTAL_ITEMS = 1600;

  typedef logic [SYM_W-1:0] sym_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } dist_result_t;

  logic              clk              = 1'b0;
  logic              rst_n            = 1'b0;
  logic              start            = 1'b0;
  logic              busy;
  logic              in_string_select = 1'b0;
  sym_t              in_symbol        = '0;
  logic              in_is_last       = 1'b0;
  logic              in_is_empty      = 1'b0;
  logic              out_valid;
  logic [DIST_W-1:0] out_distance;
  logic              out_overflow;

  // Shadow copy of the alignment state
  sym_t         first_syms [MAX_LEN];
  int unsigned  first_len;
  int unsigned  second_len;
  int unsigned  col_now  [MAX_LEN+1];
  int unsigned  col_prev [MAX_LEN+1];
  sym_t         last_second_sym;
  bit           in_second;
  bit           truncated;
  dist_result_t expected_distances [$];

  dist_result_t oldest;
  int           mismatches = 0;
  int           items_sent = 0;
  int           burst_left = 5;
  int           idle_count = 0;

  osa_edit_distance dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_string_select (in_string_select),
    .in_symbol        (in_symbol),
    .in_is_last       (in_is_last),
    .in_is_empty      (in_is_empty),
    .out_valid        (out_valid),
    .out_distance     (out_distance),
    .out_overflow     (out_overflow)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Drop the comparison and wait for a new first string
  function automatic void clear_comparison();
    first_len       = 0;
    second_len      = 0;
    last_second_sym = '0;
    in_second       = 1'b0;
    truncated       = 1'b0;
  endfunction

  // Seed both columns with the distance to the empty second string
  function automatic void open_second();
    for (int i = 0; i <= first_len; i++) begin
      col_now[i]  = i;
      col_prev[i] = i;
    end
    second_len      = 0;
    last_second_sym = '0;
    in_second       = 1'b1;
  endfunction

  // Advance the column by one second-string symbol, transpositions included
  function automatic void step_column(sym_t c);
    int unsigned next_col [MAX_LEN+1];
    int unsigned j;
    int unsigned cost;
    int unsigned v;
    j = second_len + 1;
    next_col[0] = j;
    for (int i = 1; i <= first_len; i++) begin
      cost = (first_syms[i-1] == c) ? 0 : 1;
      v = col_now[i] + 1;
      if (next_col[i-1] + 1 < v) v = next_col[i-1] + 1;
      if (col_now[i-1] + cost < v) v = col_now[i-1] + cost;
      if (i > 1 && j > 1 && first_syms[i-1] == last_second_sym && first_syms[i-2] == c &&
          col_prev[i-2] + cost < v)
        v = col_prev[i-2] + cost;
      next_col[i] = v;
    end
    for (int i = 0; i <= first_len; i++) begin
      col_prev[i] = col_now[i];
      col_now[i]  = next_col[i];
    end
    last_second_sym = c;
    second_len      = j;
  endfunction

  // Apply one accepted transfer and queue the distance it produces, if any
  function automatic void predict_distance(logic sel, sym_t sym, logic last, logic empty);
    dist_result_t r;
    if (empty && !last) return;
    if (sel == SEL_FIRST) begin
      if (in_second) clear_comparison();
      if (!empty) begin
        if (first_len < MAX_LEN) begin
          first_syms[first_len] = sym;
          first_len++;
        end else begin
          truncated = 1'b1;
        end
      end
      if (last) open_second();
    end else begin
      if (!in_second) open_second();
      if (!empty) begin
        if (second_len < MAX_LEN) step_column(sym);
        else truncated = 1'b1;
      end
      if (last) begin
        r.distance = DIST_W'(col_now[first_len]);
        r.overflow = truncated;
        expected_distances.push_back(r);
        clear_comparison();
      end
    end
  endfunction

  // Insert a random gap once the current burst runs out
  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
  endtask

  // Offer one item and hold it until the block takes the transfer
  task automatic send_item(logic sel, sym_t sym, logic last, logic empty);
    @(negedge clk);
    start            <= 1'b1;
    in_string_select <= sel;
    in_symbol        <= sym;
    in_is_last       <= last;
    in_is_empty      <= empty;
    do @(posedge clk); while (busy);
    predict_distance(sel, sym, last, empty);
    if (last || !empty) items_sent++;
    pace_sender();
  endtask

  // Hold off the sender until every outstanding distance has arrived
  task automatic wait_until_drained();
    @(negedge clk);
    start <= 1'b0;
    while (expected_distances.size() != 0) @(posedge clk);
    repeat (MAX_LEN + 4) @(posedge clk);
  endtask

  // Stream one string, with the odd ignored empty item mixed in
  task automatic send_string(logic sel, sym_t s[$], bit close, bit close_empty);
    for (int i = 0; i < s.size(); i++) begin
      if ($urandom_range(0, 19) == 0) send_item(sel, sym_t'($urandom), 1'b0, 1'b1);
      send_item(sel, s[i], close && !close_empty && i == s.size() - 1, 1'b0);
    end
    if (close && (close_empty || s.size() == 0))
      send_item(sel, sym_t'($urandom), 1'b1, 1'b1);
  endtask

  function automatic int pick_length();
    return ($urandom_range(0, 31) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 8);
  endfunction

  // One comparison over a small alphabet; the second string is often an edited copy
  task automatic run_random_pair();
    sym_t alpha [4];
    sym_t a [$];
    sym_t b [$];
    sym_t t;
    int   k;
    int   len_a;
    int   len_b;
    bit   early_second;
    for (int i = 0; i < 4; i++) alpha[i] = sym_t'($urandom);
    if ($urandom_range(0, 3) == 0) alpha[1] = alpha[0] ^ (sym_t'(1) << $urandom_range(0, SYM_W-1));
    len_a = pick_length();
    len_b = pick_length();
    repeat (len_a) a.push_back(alpha[$urandom_range(0, 3)]);
    if ($urandom_range(0, 1) == 0) begin
      b = a;
      repeat ($urandom_range(0, 3)) begin
        case ($urandom_range(0, 4))
          1: begin
            if (b.size() >= 1) b[$urandom_range(0, b.size()-1)] = alpha[$urandom_range(0, 3)];
          end
          2: begin
            if (b.size() >= 1) b.delete($urandom_range(0, b.size()-1));
          end
          3: begin
            b.insert($urandom_range(0, b.size()), alpha[$urandom_range(0, 3)]);
          end
          default: begin
            if (b.size() >= 2) begin
              k = $urandom_range(0, b.size()-2);
              t = b[k];
              b[k] = b[k+1];
              b[k+1] = t;
            end
          end
        endcase
      end
    end else begin
      repeat (len_b) b.push_back(alpha[$urandom_range(0, 3)]);
    end

    // Occasionally leave the first string open so the second one closes it
    early_second = ($urandom_range(0, 11) == 0);
    send_string(SEL_FIRST, a, !early_second, $urandom_range(0, 5) == 0);

    // Occasionally cut the second string short; the next first string abandons it
    if ($urandom_range(0, 11) == 0 && b.size() >= 1) begin
      k = $urandom_range(0, b.size()-1);
      while (b.size() > k) void'(b.pop_back());
      send_string(SEL_SECOND, b, 1'b0, 1'b0);
    end else begin
      send_string(SEL_SECOND, b, 1'b1, $urandom_range(0, 5) == 0);
    end
  endtask

  task automatic test_empty_strings();
    send_item(SEL_FIRST, '0, 1'b1, 1'b1);
    send_item(SEL_SECOND, '0, 1'b1, 1'b1);
    send_item(SEL_FIRST, '1, 1'b1, 1'b1);
    send_item(SEL_SECOND, '1, 1'b1, 1'b0);
  endtask

  task automatic test_transposition();
    send_item(SEL_FIRST, 21'h61, 1'b0, 1'b0);
    send_item(SEL_FIRST, 21'h62, 1'b1, 1'b0);
    send_item(SEL_SECOND, 21'h62, 1'b0, 1'b0);
    send_item(SEL_SECOND, 21'h61, 1'b1, 1'b0);
  endtask

  task automatic test_symbol_extremes();
    send_item(SEL_FIRST, 21'h000000, 1'b0, 1'b0);
    send_item(SEL_FIRST, 21'h1FFFFF, 1'b1, 1'b0);
    send_item(SEL_SECOND, 21'h1FFFFF, 1'b0, 1'b0);
    send_item(SEL_SECOND, 21'h0FFFFF, 1'b1, 1'b0);
  endtask

  task automatic test_ignored_empty_items();
    send_item(SEL_FIRST, 21'h15555, 1'b0, 1'b1);
    send_item(SEL_FIRST, 21'h41, 1'b1, 1'b0);
    send_item(SEL_SECOND, 21'h0AAAA, 1'b0, 1'b1);
    send_item(SEL_SECOND, 21'h41, 1'b1, 1'b0);
  endtask

  task automatic test_early_second();
    send_item(SEL_FIRST, 21'h41, 1'b0, 1'b0);
    send_item(SEL_SECOND, 21'h41, 1'b0, 1'b0);
    send_item(SEL_SECOND, 21'h42, 1'b1, 1'b0);
  endtask

  task automatic test_abandon();
    send_item(SEL_FIRST, 21'h61, 1'b1, 1'b0);
    send_item(SEL_SECOND, 21'h62, 1'b0, 1'b0);
    send_item(SEL_FIRST, 21'h63, 1'b1, 1'b0);
    send_item(SEL_SECOND, 21'h63, 1'b1, 1'b0);
  endtask

  task automatic test_empty_terminators();
    send_item(SEL_FIRST, 21'h61, 1'b0, 1'b0);
    send_item(SEL_FIRST, 21'h7F, 1'b1, 1'b1);
    send_item(SEL_SECOND, 21'h61, 1'b0, 1'b0);
    send_item(SEL_SECOND, 21'h7F, 1'b1, 1'b1);
  endtask

  // Full-length strings at the largest distance, then truncation on either side
  task automatic test_overflow();
    sym_t a [$];
    sym_t b [$];
    repeat (MAX_LEN) a.push_back('0);
    repeat (MAX_LEN) b.push_back('1);
    send_string(SEL_FIRST, a, 1'b1, 1'b0);
    send_string(SEL_SECOND, b, 1'b1, 1'b0);
    a.delete();
    b.delete();
    repeat (MAX_LEN + 2) a.push_back(sym_t'($urandom_range(0, 3)));
    repeat (3) b.push_back(sym_t'($urandom_range(0, 3)));
    send_string(SEL_FIRST, a, 1'b1, 1'b0);
    send_string(SEL_SECOND, b, 1'b1, 1'b0);
    a.delete();
    b.delete();
    repeat (2) a.push_back(sym_t'($urandom_range(0, 3)));
    repeat (MAX_LEN + 2) b.push_back(sym_t'($urandom_range(0, 3)));
    send_string(SEL_FIRST, a, 1'b1, 1'b0);
    send_string(SEL_SECOND, b, 1'b1, 1'b1);
  endtask

  // Fill the rest of the item budget with random comparisons
  task automatic test_random_pairs();
    int stop_at;
    int pairs;
    stop_at = TOTAL_ITEMS;
    pairs = 0;
    while (items_sent < stop_at) begin
      run_random_pair();
      pairs++;
      if (pairs % 50 == 0) wait_until_drained();
    end
  endtask

  // Compare each distance strobe with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_distances.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: distance %0d overflow %0b", out_distance, out_overflow);
      end else begin
        oldest = expected_distances.pop_front();
        if (out_distance !== oldest.distance || out_overflow !== oldest.overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: distance exp %0d got %0d, overflow exp %0b got %0b",
                     oldest.distance, out_distance, oldest.overflow, out_overflow);
        end
      end
    end
  end

  // End the run if no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= IDLE_LIMIT) begin
        $display("osa_edit_distance_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    clear_comparison();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_strings();
    test_transposition();
    test_symbol_extremes();
    test_ignored_empty_items();
    test_early_second();
    test_abandon();
    test_empty_terminators();
    wait_until_drained();
    test_overflow();
    wait_until_drained();
    test_random_pairs();
    wait_until_drained();

    if (mismatches == 0 && expected_distances.size() == 0) begin
      $display("osa_edit_distance_tb: done, clean");
    end else begin
      $display("osa_edit_distance_tb: done, errors");
    end
    $finish;
  end

endmodule
